// File: rtl/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared types, constants and helpers of the page frame buffer refresh unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pfr_pkg;

  localparam int WIDTH     = 128;
  localparam int PAGES     = 8;
  localparam int HEIGHT    = PAGES * 8;
  localparam int STORE     = WIDTH * PAGES;
  localparam int CMD_STEPS = 3;

  localparam int COL_W   = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int ADDR_W  = $clog2(STORE);
  localparam int CNT_W   = $clog2(STORE + 1);
  localparam int STEP_W  = $clog2(WIDTH + CMD_STEPS);
  localparam int SPAN_W  = $clog2(WIDTH + 1);
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);

  typedef logic [2:0]        kind_t;
  typedef logic [7:0]        byte_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [STEP_W-1:0] step_t;
  typedef logic [SPAN_W-1:0] span_t;

  localparam kind_t KIND_PIXEL     = 3'd0;
  localparam kind_t KIND_CLEAR_ALL = 3'd1;
  localparam kind_t KIND_SPAN      = 3'd2;
  localparam kind_t KIND_START     = 3'd3;
  localparam kind_t KIND_TICK      = 3'd4;

  localparam byte_t CMD_PAGE_BASE = 8'hB0;
  localparam byte_t CMD_COL_HIGH  = 8'h10;
  localparam byte_t CMD_COL_LOW   = 8'h00;

  typedef enum logic [2:0] {
    OP_PIXEL,
    OP_CLEAR_ALL,
    OP_SPAN,
    OP_START,
    OP_TICK
  } op_code_t;

  typedef struct packed {
    op_code_t code;
    addr_t    addr;
    byte_t    mask;
    logic     pixel_on;
    span_t    span_len;
  } op_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_PIX,
    BK_TICK,
    BK_SWEEP
  } bk_state_t;

  typedef struct packed {
    logic init_busy;
  } bk_stat_t;

  function automatic addr_t store_addr(page_t p, col_t c);
    return addr_t'(addr_t'(p) * addr_t'(WIDTH) + addr_t'(c));
  endfunction

endpackage

`default_nettype wire

// File: rtl/pfr_ifs.sv
// ----------------------------------------------------------------------------
// pfr_ifs
// Request and result channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfr_in_if import pfr_pkg::*; ();
  logic  valid;
  logic  ready;
  kind_t kind;
  byte_t col_x;
  byte_t row_y;
  byte_t page_sel;
  byte_t span_length;
  logic  pixel_on;

  modport source (output valid, kind, col_x, row_y, page_sel, span_length, pixel_on,
                  input ready);
  modport sink   (input valid, kind, col_x, row_y, page_sel, span_length, pixel_on,
                  output ready);
endinterface

interface pfr_out_if import pfr_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t link_byte;
  logic  data_not_command;
  logic  frame_end;

  modport source (output valid, link_byte, data_not_command, frame_end, input ready);
  modport sink   (input valid, link_byte, data_not_command, frame_end, output ready);
endinterface

`default_nettype wire

// File: rtl/pfr_ram.sv
// ----------------------------------------------------------------------------
// pfr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_ram #(
  parameter int W = 8,
  parameter int D = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/pfr_front.sv
// ----------------------------------------------------------------------------
// pfr_front
// Accepts requests, drops ignored ones and turns the rest into store ops.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_front import pfr_pkg::*; (
  pfr_in_if.sink         in_chan,
  input  wire logic      q_full,
  input  wire bk_stat_t  bk_stat,
  output logic           push,
  output op_t            push_op
);

  logic       keep;
  logic [8:0] span_end;

  assign in_chan.ready = !q_full && !bk_stat.init_busy;
  assign span_end      = 9'(in_chan.col_x) + 9'(in_chan.span_length);

  always_comb begin
    keep             = 1'b0;
    push_op.code     = OP_TICK;
    push_op.addr     = store_addr(page_t'(in_chan.row_y[3 +: PAGE_W]), col_t'(in_chan.col_x));
    push_op.mask     = byte_t'(8'd1 << in_chan.row_y[2:0]);
    push_op.pixel_on = in_chan.pixel_on;
    push_op.span_len = span_t'(in_chan.span_length);
    unique case (in_chan.kind)
      KIND_PIXEL: begin
        push_op.code = OP_PIXEL;
        keep = (9'(in_chan.col_x) < 9'(WIDTH)) && (9'(in_chan.row_y) < 9'(HEIGHT));
      end
      KIND_CLEAR_ALL: begin
        push_op.code = OP_CLEAR_ALL;
        keep = 1'b1;
      end
      KIND_SPAN: begin
        push_op.code = OP_SPAN;
        push_op.addr = store_addr(page_t'(in_chan.page_sel), col_t'(in_chan.col_x));
        keep = (9'(in_chan.page_sel) < 9'(PAGES)) && (span_end <= 9'(WIDTH)) &&
               (in_chan.span_length != 8'd0);
      end
      KIND_START: begin
        push_op.code = OP_START;
        keep = 1'b1;
      end
      KIND_TICK: begin
        push_op.code = OP_TICK;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = in_chan.valid && in_chan.ready && keep;

endmodule

`default_nettype wire

// File: rtl/pfr_queue.sv
// ----------------------------------------------------------------------------
// pfr_queue
// Short op queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_queue import pfr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire op_t  push_op,
  input  wire logic pop,
  output op_t       head_op,
  output logic      empty,
  output logic      full
);

  op_t                mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]    count_r, count_nxt;
  logic               do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (QPTR_W+1)'(QDEPTH));
  assign head_op = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pfr_back.sv
// ----------------------------------------------------------------------------
// pfr_back
// Executes store ops: pixel read-modify-write, clear sweeps, refresh stream.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_back import pfr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire op_t    head_op,
  input  wire logic   q_empty,
  output logic        pop,
  output bk_stat_t    bk_stat,
  output logic        ram_we,
  output addr_t       ram_waddr,
  output byte_t       ram_wdata,
  output logic        ram_re,
  output addr_t       ram_raddr,
  input  wire byte_t  ram_rdata,
  pfr_out_if.source   out_chan
);

  bk_state_t state_r, state_nxt;

  logic  active_r, active_nxt;
  page_t page_r, page_nxt;
  step_t step_r, step_nxt;

  addr_t sweep_addr_r, sweep_addr_nxt;
  cnt_t  sweep_left_r, sweep_left_nxt;

  addr_t pend_addr_r, pend_addr_nxt;
  byte_t pend_mask_r, pend_mask_nxt;
  logic  pend_on_r, pend_on_nxt;
  logic  pend_fend_r, pend_fend_nxt;

  logic  out_valid_r, out_valid_nxt;
  byte_t out_byte_r, out_byte_nxt;
  logic  out_dnc_r, out_dnc_nxt;
  logic  out_fend_r, out_fend_nxt;
  logic  out_load;
  logic  out_free;

  logic            is_cmd;
  logic [STEP_W:0] step_inc;
  logic [PAGE_W:0] page_inc;
  logic            step_wrap;
  logic            last_page;
  byte_t           cmd_byte;
  col_t            data_col;

  assign out_free  = !out_valid_r || out_chan.ready;
  assign is_cmd    = (step_r < step_t'(CMD_STEPS));
  assign step_inc  = (STEP_W+1)'(step_r) + 1'b1;
  assign page_inc  = (PAGE_W+1)'(page_r) + 1'b1;
  assign step_wrap = (step_inc >= (STEP_W+1)'(CMD_STEPS + WIDTH));
  assign last_page = (page_inc >= (PAGE_W+1)'(PAGES));
  assign data_col  = col_t'(step_r - step_t'(CMD_STEPS));

  always_comb begin
    case (step_r)
      step_t'(0): cmd_byte = byte_t'(CMD_PAGE_BASE + byte_t'(page_r));
      step_t'(1): cmd_byte = CMD_COL_HIGH;
      default:    cmd_byte = CMD_COL_LOW;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r) inside
      BK_INIT, BK_SWEEP: begin
        if (sweep_left_r == cnt_t'(1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          unique case (head_op.code) inside
            OP_PIXEL:             state_nxt = BK_PIX;
            OP_CLEAR_ALL, OP_SPAN: state_nxt = BK_SWEEP;
            OP_TICK: begin
              if (active_r && !is_cmd) begin
                state_nxt = BK_TICK;
              end
            end
            default:              state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_PIX: state_nxt = BK_IDLE;
      BK_TICK: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop            = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = sweep_addr_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = head_op.addr;
    out_load       = 1'b0;
    out_byte_nxt   = out_byte_r;
    out_dnc_nxt    = out_dnc_r;
    out_fend_nxt   = out_fend_r;
    active_nxt     = active_r;
    page_nxt       = page_r;
    step_nxt       = step_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_left_nxt = sweep_left_r;
    pend_addr_nxt  = pend_addr_r;
    pend_mask_nxt  = pend_mask_r;
    pend_on_nxt    = pend_on_r;
    pend_fend_nxt  = pend_fend_r;

    unique case (state_r) inside
      BK_INIT, BK_SWEEP: begin
        ram_we         = 1'b1;
        ram_waddr      = sweep_addr_r;
        ram_wdata      = '0;
        sweep_addr_nxt = sweep_addr_r + 1'b1;
        sweep_left_nxt = sweep_left_r - 1'b1;
      end
      BK_IDLE: begin
        if (!q_empty) begin
          unique case (head_op.code)
            OP_PIXEL: begin
              pop           = 1'b1;
              ram_re        = 1'b1;
              ram_raddr     = head_op.addr;
              pend_addr_nxt = head_op.addr;
              pend_mask_nxt = head_op.mask;
              pend_on_nxt   = head_op.pixel_on;
            end
            OP_CLEAR_ALL: begin
              pop            = 1'b1;
              sweep_addr_nxt = '0;
              sweep_left_nxt = cnt_t'(STORE);
            end
            OP_SPAN: begin
              pop            = 1'b1;
              sweep_addr_nxt = head_op.addr;
              sweep_left_nxt = cnt_t'(head_op.span_len);
            end
            OP_START: begin
              pop        = 1'b1;
              active_nxt = 1'b1;
              page_nxt   = '0;
              step_nxt   = '0;
            end
            OP_TICK: begin
              if (!active_r) begin
                pop = 1'b1;
              end else if (!is_cmd || out_free) begin
                pop = 1'b1;
                step_nxt = step_t'(step_inc);
                if (step_wrap) begin
                  step_nxt = '0;
                  page_nxt = page_t'(page_inc);
                  if (last_page) begin
                    page_nxt   = '0;
                    active_nxt = 1'b0;
                  end
                end
                if (is_cmd) begin
                  out_load     = 1'b1;
                  out_byte_nxt = cmd_byte;
                  out_dnc_nxt  = 1'b0;
                  out_fend_nxt = 1'b0;
                end else begin
                  ram_re        = 1'b1;
                  ram_raddr     = store_addr(page_r, data_col);
                  pend_fend_nxt = step_wrap && last_page;
                end
              end
            end
            default: pop = 1'b0;
          endcase
        end
      end
      BK_PIX: begin
        ram_we    = 1'b1;
        ram_waddr = pend_addr_r;
        ram_wdata = pend_on_r ? (ram_rdata | pend_mask_r) : (ram_rdata & ~pend_mask_r);
      end
      BK_TICK: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_byte_nxt = ram_rdata;
          out_dnc_nxt  = 1'b1;
          out_fend_nxt = pend_fend_r;
        end
      end
      default: pop = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_INIT;
      active_r     <= 1'b0;
      page_r       <= '0;
      step_r       <= '0;
      sweep_addr_r <= '0;
      sweep_left_r <= cnt_t'(STORE);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      active_r     <= active_nxt;
      page_r       <= page_nxt;
      step_r       <= step_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_left_r <= sweep_left_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    pend_mask_r <= pend_mask_nxt;
    pend_on_r   <= pend_on_nxt;
    pend_fend_r <= pend_fend_nxt;
    out_byte_r  <= out_byte_nxt;
    out_dnc_r   <= out_dnc_nxt;
    out_fend_r  <= out_fend_nxt;
  end

  assign bk_stat.init_busy = (state_r == BK_INIT);

  assign out_chan.valid            = out_valid_r;
  assign out_chan.link_byte        = out_byte_r;
  assign out_chan.data_not_command = out_dnc_r;
  assign out_chan.frame_end        = out_fend_r;

endmodule

`default_nettype wire

// File: rtl/page_framebuffer_refresh_unit.sv
// Path: a command tick reaches the output through the queue and the output register;
//   a data tick through the queue, the store read and the output register.
// Back end: a pixel write takes a store read, then a write-back; a data tick a store read,
//   then an output load that waits for a free output; command ticks and refresh starts take
//   only the idle state; span clear and clear-all zero one store entry per cycle through the single write port.
// Reset: synchronous; a clearing pass zeroes the whole store, in_chan.ready low.
// ----------------------------------------------------------------------------
// page_framebuffer_refresh_unit
// Page-addressed monochrome frame store with panel refresh stream output.
// ----------------------------------------------------------------------------
`default_nettype none

module page_framebuffer_refresh_unit import pfr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  pfr_in_if.sink    in_chan,
  pfr_out_if.source out_chan
);

  logic     push;
  op_t      push_op;
  op_t      head_op;
  logic     q_empty;
  logic     q_full;
  logic     pop;
  bk_stat_t bk_stat;
  logic     ram_we;
  addr_t    ram_waddr;
  byte_t    ram_wdata;
  logic     ram_re;
  addr_t    ram_raddr;
  byte_t    ram_rdata;

  pfr_front u_front (
    .in_chan (in_chan),
    .q_full  (q_full),
    .bk_stat (bk_stat),
    .push    (push),
    .push_op (push_op)
  );

  pfr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .empty   (q_empty),
    .full    (q_full)
  );

  pfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_op   (head_op),
    .q_empty   (q_empty),
    .pop       (pop),
    .bk_stat   (bk_stat),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_chan  (out_chan)
  );

  pfr_ram #(
    .W (8),
    .D (STORE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// File: rtl/pfr_checker.sv
// ----------------------------------------------------------------------------
// pfr_checker
// Port-level checks of the refresh unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_checker import pfr_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  input wire logic  in_ready,
  input wire logic  out_valid,
  input wire logic  out_ready,
  input wire byte_t out_link_byte,
  input wire logic  out_data_not_command,
  input wire logic  out_frame_end
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_link_byte) &&
    $stable(out_data_not_command) && $stable(out_frame_end))
    else $error("stalled result changed");

  // frame end only on data bytes
  a_fend_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_data_not_command)
    else $error("frame end on command byte");

  // command bytes are page address or column address
  a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data_not_command |->
    (out_link_byte[7:4] == CMD_PAGE_BASE[7:4]) || (out_link_byte == CMD_COL_HIGH) ||
    (out_link_byte == CMD_COL_LOW))
    else $error("bad command byte");

  // clearing pass holds off requests right after reset
  a_init_block: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready)
    else $error("request taken during clearing pass");

endmodule

bind page_framebuffer_refresh_unit pfr_checker u_pfr_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_ready             (in_chan.ready),
  .out_valid            (out_chan.valid),
  .out_ready            (out_chan.ready),
  .out_link_byte        (out_chan.link_byte),
  .out_data_not_command (out_chan.data_not_command),
  .out_frame_end        (out_chan.frame_end)
);

`default_nettype wire
